@@ hdl/hbw_pkg.sv @@
package hbw_pkg;

   // Default sizing
   localparam int CHANNELS_DEF    = 4;
   localparam int ERROR_BITS_DEF  = 32;

   // Channels that own an error map register
   localparam int MAPPED_CHANNELS = 4;

   localparam int CNT_W     = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   localparam logic [CNT_W-1:0] RELOAD_RESET = 8'd50;
   localparam logic [31:0]      MAP0_RESET   = 32'h0001_0000;
   localparam logic [31:0]      MAP1_RESET   = 32'h0002_0000;
   localparam logic [31:0]      MAP2_RESET   = 32'h0004_0000;
   localparam logic [31:0]      MAP3_RESET   = 32'h0008_0000;

   // Request kinds
   typedef enum logic [2:0] {
      REQ_TICK   = 3'd0,
      REQ_BEACON = 3'd1,
      REQ_SET    = 3'd2,
      REQ_CLEAR  = 3'd3,
      REQ_STATUS = 3'd4
   } req_kind_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RELOAD = 3'd0,
      CSR_MAP0   = 3'd1,
      CSR_MAP1   = 3'd2,
      CSR_MAP2   = 3'd3,
      CSR_MAP3   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [3:0]  channel;
      logic [31:0] mask;
   } req_type_type;

   typedef struct packed {
      logic [31:0] error_list;
      logic [31:0] status_bits;
      logic [3:0]  expired_channels;
   } rsp_type_type;

endpackage

@@ hdl/hbw_update.sv @@
module hbw_update #(
   parameter int CHANNELS   = hbw_pkg::CHANNELS_DEF,
   parameter int ERROR_BITS = hbw_pkg::ERROR_BITS_DEF
) (
   input  hbw_pkg::req_type_type                        req,
   input  logic [ERROR_BITS-1:0]                        err,
   input  logic [CHANNELS-1:0][hbw_pkg::CNT_W-1:0]      cnt,
   input  logic [hbw_pkg::CNT_W-1:0]                    reload,
   input  logic [hbw_pkg::MAPPED_CHANNELS-1:0][31:0]    maps,
   output logic [ERROR_BITS-1:0]                        err_in,
   output logic [CHANNELS-1:0][hbw_pkg::CNT_W-1:0]      cnt_in,
   output hbw_pkg::rsp_type_type                        rsp
);

   localparam int NMAP  = (CHANNELS < hbw_pkg::MAPPED_CHANNELS) ?
                          CHANNELS : hbw_pkg::MAPPED_CHANNELS;
   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [63:0]                  mask_wide;
   logic [ERROR_BITS-1:0]        m;
   logic [NMAP-1:0][ERROR_BITS-1:0] bits;
   logic [63:0]                  map_wide;
   logic [63:0]                  err_wide;
   logic [63:0]                  stat_wide;
   logic [3:0]                   expired;
   logic                         beacon_hit;
   logic                         beacon_mapped;

   // Trim mask and maps to the register width
   always_comb begin
      mask_wide = {32'b0, req.mask};
      m         = mask_wide[ERROR_BITS-1:0];
      for (int j = 0; j < NMAP; j++) begin
         map_wide = {32'b0, maps[j]};
         bits[j]  = map_wide[ERROR_BITS-1:0];
      end
      if (NMAP == 0) begin
         map_wide = '0;
      end
   end

   assign beacon_hit    = ({1'b0, req.channel} < 5'(CHANNELS));
   assign beacon_mapped = ({1'b0, req.channel} < 5'(NMAP));

   // Next register and counter values
   always_comb begin
      err_in  = err;
      cnt_in  = cnt;
      expired = '0;
      unique case (req.req_type)
         hbw_pkg::REQ_TICK: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (cnt[i] != '0) begin
                  cnt_in[i] = cnt[i] - 1'b1;
               end
            end
            // Expiry runs in channel order: earlier raises mask later ones
            for (int j = 0; j < NMAP; j++) begin
               if (cnt[j] == '0 && (err_in & bits[j]) == '0) begin
                  err_in     = err_in | bits[j];
                  expired[j] = 1'b1;
               end
            end
         end
         hbw_pkg::REQ_BEACON: begin
            if (beacon_hit) begin
               cnt_in[req.channel[IDX_W-1:0]] = reload;
            end
            for (int j = 0; j < NMAP; j++) begin
               if (beacon_mapped && req.channel == 4'(j)) begin
                  err_in = err_in & ~bits[j];
               end
            end
         end
         hbw_pkg::REQ_SET: begin
            if ((err & m) == '0) begin
               err_in = err | m;
            end
         end
         hbw_pkg::REQ_CLEAR: begin
            err_in = err & ~m;
         end
         default: begin
            err_in = err;
         end
      endcase
   end

   // Build the result beat
   always_comb begin
      err_wide                   = '0;
      err_wide[ERROR_BITS-1:0]   = err_in;
      stat_wide                  = '0;
      stat_wide[ERROR_BITS-1:0]  = err_in & m;
      rsp.error_list             = err_wide[31:0];
      rsp.status_bits            = stat_wide[31:0];
      rsp.expired_channels       = expired;
   end

endmodule

@@ hdl/heartbeat_watchdog_error_register_unit.sv @@
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_data  (hbw_pkg::req_type_type)
// rsp      out        rsp_valid/rsp_ready  rsp_data  (hbw_pkg::rsp_type_type)
// csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One request beat per cycle while the result side is not stalled; a request
// lands in the input register when accepted, its update is then loaded into
// the result register, and the result beat is on rsp from there.
// Reset (synchronous) clears the error register, loads every counter and the
// reload register with 50 and the channel maps with their defaults.
// A stalled result holds the update stage; the input register still takes a
// beat whenever the update stage moves on.
module heartbeat_watchdog_error_register_unit #(
   parameter int CHANNELS   = hbw_pkg::CHANNELS_DEF,
   parameter int ERROR_BITS = hbw_pkg::ERROR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  hbw_pkg::req_type_type           req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output hbw_pkg::rsp_type_type           rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hbw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hbw_pkg::CSR_DAT_W-1:0]   csr_data
);

   logic                                         in_vld_ff;
   hbw_pkg::req_type_type                        in_req_ff;
   logic                                         rsp_vld_ff;
   hbw_pkg::rsp_type_type                        rsp_ff;
   logic [ERROR_BITS-1:0]                        err_ff;
   logic [ERROR_BITS-1:0]                        err_in;
   logic [CHANNELS-1:0][hbw_pkg::CNT_W-1:0]      cnt_ff;
   logic [CHANNELS-1:0][hbw_pkg::CNT_W-1:0]      cnt_in;
   logic [hbw_pkg::CNT_W-1:0]                    reload_ff;
   logic [hbw_pkg::MAPPED_CHANNELS-1:0][31:0]    map_ff;
   hbw_pkg::rsp_type_type                        rsp_in;
   logic                                         fire;
   logic                                         req_take;

   // Advance the update stage when the result slot is free or draining
   assign fire      = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   hbw_update #(
      .CHANNELS   (CHANNELS),
      .ERROR_BITS (ERROR_BITS)
   ) u_update (
      .req    (in_req_ff),
      .err    (err_ff),
      .cnt    (cnt_ff),
      .reload (reload_ff),
      .maps   (map_ff),
      .err_in (err_in),
      .cnt_in (cnt_in),
      .rsp    (rsp_in)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
      if (req_take) begin
         in_req_ff <= req_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Watchdog state
   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            cnt_ff[i] <= hbw_pkg::RELOAD_RESET;
         end
      end else if (fire) begin
         err_ff <= err_in;
         cnt_ff <= cnt_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= hbw_pkg::RELOAD_RESET;
         map_ff[0] <= hbw_pkg::MAP0_RESET;
         map_ff[1] <= hbw_pkg::MAP1_RESET;
         map_ff[2] <= hbw_pkg::MAP2_RESET;
         map_ff[3] <= hbw_pkg::MAP3_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            hbw_pkg::CSR_RELOAD: reload_ff <= csr_data[hbw_pkg::CNT_W-1:0];
            hbw_pkg::CSR_MAP0:   map_ff[0] <= csr_data;
            hbw_pkg::CSR_MAP1:   map_ff[1] <= csr_data;
            hbw_pkg::CSR_MAP2:   map_ff[2] <= csr_data;
            hbw_pkg::CSR_MAP3:   map_ff[3] <= csr_data;
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

endmodule

@@ tb/sv/heartbeat_watchdog_error_register_unit_tb.sv @@
`timescale 1ns / 100ps

module heartbeat_watchdog_error_register_unit_tb;

   localparam int NUM_CH       = hbw_pkg::CHANNELS_DEF;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int PIPE_SLACK   = 4;
   localparam int STALL_CYCLES = 60;
   localparam int PRINT_CAP    = 50;

   // request kinds the block must ignore
   localparam logic [2:0] REQ_RSVD_FIRST = 3'd5;
   localparam logic [2:0] REQ_RSVD_LAST  = 3'd7;
   localparam logic [hbw_pkg::CSR_IDX_W-1:0] CSR_SPARE_LAST = 3'd7;

   localparam logic [3:0]  CH_TOP   = 4'd15;
   localparam logic [3:0]  CH_FIRST_UNUSED = 4'd4;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   hbw_pkg::req_type_type           req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   hbw_pkg::rsp_type_type           rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [hbw_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [hbw_pkg::CSR_DAT_W-1:0]   csr_data = '0;

   // watchdog image kept by the testbench
   logic [31:0]                     wd_err;
   logic [hbw_pkg::CNT_W-1:0]       wd_count [NUM_CH];
   logic [hbw_pkg::CNT_W-1:0]       wd_reload;
   logic [31:0]                     wd_map [hbw_pkg::MAPPED_CHANNELS];

   hbw_pkg::rsp_type_type           pending_rsp [$];

   int                      req_idle_pct;
   int                      rsp_idle_pct;
   int                      hold_left = 0;
   bit                      hold_kick = 1'b0;

   int                      mismatches = 0;
   int                      beats_in = 0;
   int                      beats_out = 0;
   int                      expiry_beats = 0;
   int                      csr_writes = 0;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  chan;
      logic [31:0] mask;
      logic        typed;
      logic [31:0] err;
      logic [31:0] stat;
      logic [3:0]  fresh;
   } plan_row_type;

   // opening sequence, run with reload 0 and maps 0 / all ones / bit 0 / bit 31
   plan_row_type opening_plan [0:22] = '{
      '{hbw_pkg::REQ_STATUS, 4'd0, ALL_ONES, 1'b1, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_SET, 4'd0, ALL_ONES, 1'b1, ALL_ONES, ALL_ONES, 4'h0},
      '{hbw_pkg::REQ_SET, 4'd0, 32'h1, 1'b1, ALL_ONES, 32'h1, 4'h0},
      '{hbw_pkg::REQ_CLEAR, 4'd0, ALL_ONES, 1'b1, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_SET, 4'd0, 32'h0, 1'b1, 32'h0, 32'h0, 4'h0},
      '{REQ_RSVD_FIRST, 4'd0, ALL_ONES, 1'b1, 32'h0, 32'h0, 4'h0},
      '{REQ_RSVD_LAST, CH_TOP, 32'h0, 1'b1, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_BEACON, CH_TOP, ALL_ONES, 1'b1, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_BEACON, CH_FIRST_UNUSED, ALL_ONES, 1'b1, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_TICK, 4'd0, ALL_ONES, 1'b1, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_BEACON, 4'd0, 32'h0, 1'b1, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_BEACON, 4'd1, 32'h0, 1'b1, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_BEACON, 4'd2, 32'h0, 1'b1, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_BEACON, 4'd3, 32'h0, 1'b1, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_TICK, 4'd0, ALL_ONES, 1'b0, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_TICK, 4'd0, 32'h0, 1'b0, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_BEACON, 4'd1, ALL_ONES, 1'b0, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_TICK, 4'd0, ALL_ONES, 1'b0, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_CLEAR, 4'd0, 32'h8000_0001, 1'b0, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_TICK, 4'd0, ALL_ONES, 1'b0, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_STATUS, 4'd0, 32'h0000_FFFF, 1'b0, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_SET, 4'd0, 32'h00FF_0000, 1'b0, 32'h0, 32'h0, 4'h0},
      '{hbw_pkg::REQ_STATUS, 4'd0, ALL_ONES, 1'b0, 32'h0, 32'h0, 4'h0}
   };

   heartbeat_watchdog_error_register_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #1_000_000;
      $display("heartbeat_watchdog_error_register_unit_tb: FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_CAP)
         $display("%0t ns mismatch: %s got %h want %h", $time, what, got, want);
      mismatches++;
   endtask

   // apply one request to the image and produce its result beat
   task automatic advance_watchdog(input hbw_pkg::req_type_type r,
                                   output hbw_pkg::rsp_type_type o);
      logic [3:0] fresh;
      fresh = '0;
      unique case (r.req_type)
         hbw_pkg::REQ_TICK: begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
               if (wd_count[ch] != '0) begin
                  wd_count[ch] = wd_count[ch] - 1'b1;
               end else if ((wd_err & wd_map[ch]) == '0) begin
                  // a zero map still counts as a fresh expiry
                  wd_err    = wd_err | wd_map[ch];
                  fresh[ch] = 1'b1;
               end
            end
         end
         hbw_pkg::REQ_BEACON: begin
            if (r.channel < NUM_CH) begin
               wd_count[r.channel] = wd_reload;
               wd_err = wd_err & ~wd_map[r.channel];
            end
         end
         hbw_pkg::REQ_SET: begin
            // any overlap leaves the register alone
            if ((wd_err & r.mask) == '0)
               wd_err = wd_err | r.mask;
         end
         hbw_pkg::REQ_CLEAR: begin
            wd_err = wd_err & ~r.mask;
         end
         default: begin
         end
      endcase
      o.error_list       = wd_err;
      o.status_bits      = wd_err & r.mask;
      o.expired_channels = fresh;
   endtask

   // offer one request beat, then record what it must produce
   task automatic send_req(input hbw_pkg::req_type_type r, input logic use_given,
                           input hbw_pkg::rsp_type_type given);
      hbw_pkg::rsp_type_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_ready !== 1'b1)
         @(posedge clock);
      advance_watchdog(r, predicted);
      pending_rsp.push_back(use_given ? given : predicted);
      beats_in++;
   endtask

   task automatic write_csr(input logic [hbw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      unique case (idx)
         hbw_pkg::CSR_RELOAD: wd_reload = val[hbw_pkg::CNT_W-1:0];
         hbw_pkg::CSR_MAP0, hbw_pkg::CSR_MAP1, hbw_pkg::CSR_MAP2, hbw_pkg::CSR_MAP3:
            wd_map[idx - hbw_pkg::CSR_MAP0] = val;
         default: begin
         end
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_csrs(input logic [7:0] reload, input logic [31:0] m0,
                               input logic [31:0] m1, input logic [31:0] m2,
                               input logic [31:0] m3);
      write_csr(hbw_pkg::CSR_RELOAD, {24'h0, reload});
      write_csr(hbw_pkg::CSR_MAP0, m0);
      write_csr(hbw_pkg::CSR_MAP1, m1);
      write_csr(hbw_pkg::CSR_MAP2, m2);
      write_csr(hbw_pkg::CSR_MAP3, m3);
   endtask

   // wait for every pending result, then let the pipe go quiet
   task automatic settle_out();
      int waited;
      waited = 0;
      while (pending_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_rsp.size() != 0) begin
         report_mismatch("results never delivered, count", pending_rsp.size(), 32'h0);
         pending_rsp.delete();
      end
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   task automatic run_phase(input int count);
      hbw_pkg::req_type_type r;
      int sel;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         // mostly live channels, sometimes the unused range
         r.channel = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 4))
                                              : 4'($urandom_range(NUM_CH - 1));
         case ($urandom_range(5))
            0:       r.mask = $urandom;
            1:       r.mask = 32'h1 << $urandom_range(31);
            2:       r.mask = wd_map[$urandom_range(hbw_pkg::MAPPED_CHANNELS - 1)];
            3:       r.mask = '0;
            4:       r.mask = ALL_ONES;
            default: r.mask = $urandom & $urandom;
         endcase
         if (sel < 42)
            r.req_type = hbw_pkg::REQ_TICK;
         else if (sel < 67)
            r.req_type = hbw_pkg::REQ_BEACON;
         else if (sel < 79)
            r.req_type = hbw_pkg::REQ_SET;
         else if (sel < 89)
            r.req_type = hbw_pkg::REQ_CLEAR;
         else if (sel < 95)
            r.req_type = hbw_pkg::REQ_STATUS;
         else
            r.req_type = 3'($urandom_range(REQ_RSVD_LAST, REQ_RSVD_FIRST));
         send_req(r, 1'b0, '0);
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // result side: random back-pressure plus one long hold on request
   always @(negedge clock) begin
      if (hold_kick) begin
         hold_kick = 1'b0;
         hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // compare each result beat with the oldest pending one
   always @(posedge clock) begin
      hbw_pkg::rsp_type_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         beats_out++;
         if (rsp_data.expired_channels != '0)
            expiry_beats++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("result beat with nothing pending", rsp_data.error_list, 32'h0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.error_list !== want.error_list)
               report_mismatch("error_list", rsp_data.error_list, want.error_list);
            if (rsp_data.status_bits !== want.status_bits)
               report_mismatch("status_bits", rsp_data.status_bits, want.status_bits);
            if (rsp_data.expired_channels !== want.expired_channels)
               report_mismatch("expired_channels", {28'h0, rsp_data.expired_channels},
                               {28'h0, want.expired_channels});
         end
      end
   end

   initial begin
      hbw_pkg::req_type_type r;
      hbw_pkg::rsp_type_type given;

      wd_err    = '0;
      wd_reload = hbw_pkg::RELOAD_RESET;
      wd_map[0] = hbw_pkg::MAP0_RESET;
      wd_map[1] = hbw_pkg::MAP1_RESET;
      wd_map[2] = hbw_pkg::MAP2_RESET;
      wd_map[3] = hbw_pkg::MAP3_RESET;
      for (int ch = 0; ch < NUM_CH; ch++)
         wd_count[ch] = hbw_pkg::RELOAD_RESET;
      req_idle_pct = 12;
      rsp_idle_pct = 49;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening: zero reload, extreme maps
      program_csrs(8'd0, 32'h0, ALL_ONES, 32'h1, 32'h8000_0000);
      foreach (opening_plan[i]) begin
         r.req_type               = opening_plan[i].kind;
         r.channel                = opening_plan[i].chan;
         r.mask                   = opening_plan[i].mask;
         given.error_list         = opening_plan[i].err;
         given.status_bits        = opening_plan[i].stat;
         given.expired_channels   = opening_plan[i].fresh;
         send_req(r, opening_plan[i].typed, given);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      settle_out();

      // short timeouts, three single-bit maps and one random map, spare register indexes
      program_csrs(8'($urandom_range(6, 1)), 32'h1 << $urandom_range(31),
                   32'h1 << $urandom_range(31), $urandom, 32'h1 << $urandom_range(31));
      for (int k = hbw_pkg::CSR_MAP3 + 1; k <= CSR_SPARE_LAST; k++)
         write_csr(hbw_pkg::CSR_IDX_W'(k), $urandom);
      run_phase(640);
      settle_out();

      // longest timeout, dense maps, sender now the slow side
      req_idle_pct = 49;
      rsp_idle_pct = 12;
      program_csrs(8'd255, $urandom, $urandom, $urandom, $urandom);
      run_phase(630);
      settle_out();

      // overlapping low-byte maps, one empty map, full rate with a long stall
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      program_csrs(8'($urandom_range(10, 2)), 32'($urandom_range(255)),
                   32'($urandom_range(255)), 32'($urandom_range(255)), 32'h0);
      hold_kick = 1'b1;
      run_phase(630);
      settle_out();

      $display("run covered %0d request beats and %0d register writes over four settings",
               beats_in, csr_writes);
      $display("checked %0d result beats, %0d of them with fresh expiries, %0d mismatches",
               beats_out, expiry_beats, mismatches);
      if (mismatches == 0)
         $display("heartbeat_watchdog_error_register_unit_tb: PASS");
      else
         $display("heartbeat_watchdog_error_register_unit_tb: FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/hbw_pkg.sv
hdl/hbw_update.sv
hdl/heartbeat_watchdog_error_register_unit.sv
tb/sv/heartbeat_watchdog_error_register_unit_tb.sv
